### rtl/rpml_pkg.sv
// Package for the ramped PI motor speed loop.
// Shared widths, reset values, the configuration bundle and the stage payload.
// No dependencies.
package rpml_pkg;

  localparam int MOTOR_W = 3;
  localparam int RPM_W   = 14;
  localparam int STEP_W  = 12;
  localparam int GAIN_W  = 16;
  localparam int PWM_W   = 16;
  localparam int CNT_W   = 8;
  localparam int ERR_W   = RPM_W + 1;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [PWM_W-1:0] PWM_CEILING_RST    = 16'd1499;
  localparam logic [RPM_W-1:0] ERROR_LIMIT_RST    = 14'd300;
  localparam logic [CNT_W-1:0] OVERLOAD_TICKS_RST = 8'd20;

  typedef struct packed {
    logic [PWM_W-1:0] pwm_ceiling;
    logic [RPM_W-1:0] error_limit;
    logic [CNT_W-1:0] overload_ticks;
  } cfg_t;

  // Payload handed from the state stage to the PWM stage.
  typedef struct packed {
    logic [MOTOR_W-1:0]     motor;
    logic                   oob;
    logic [RPM_W-1:0]       tgt;
    logic                   fault;
    logic [GAIN_W-1:0]      kp;
    logic [GAIN_W-1:0]      ki;
    logic [PWM_W-1:0]       flo;
    logic signed [ERR_W-1:0] err;
  } s2_t;

endpackage

### rtl/rpml_cfg_regs.sv
// APB-style configuration registers of the motor speed loop.
// Depends on rpml_pkg (cfg_t, reset values, bus widths).
module rpml_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpml_pkg::APB_AW-1:0] paddr,
  input  logic [rpml_pkg::APB_DW-1:0] pwdata,
  output logic [rpml_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output rpml_pkg::cfg_t              cfg_o
);
  import rpml_pkg::*;

  localparam logic [1:0] REG_PWM_CEILING    = 2'd0;
  localparam logic [1:0] REG_ERROR_LIMIT    = 2'd1;
  localparam logic [1:0] REG_OVERLOAD_TICKS = 2'd2;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PWM_CEILING:    cfg_d.pwm_ceiling    = pwdata[PWM_W-1:0];
        REG_ERROR_LIMIT:    cfg_d.error_limit    = pwdata[RPM_W-1:0];
        REG_OVERLOAD_TICKS: cfg_d.overload_ticks = pwdata[CNT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PWM_CEILING:    prdata = APB_DW'(cfg_q.pwm_ceiling);
      REG_ERROR_LIMIT:    prdata = APB_DW'(cfg_q.error_limit);
      REG_OVERLOAD_TICKS: prdata = APB_DW'(cfg_q.overload_ticks);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_ceiling    <= PWM_CEILING_RST;
      cfg_q.error_limit    <= ERROR_LIMIT_RST;
      cfg_q.overload_ticks <= OVERLOAD_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/rpml_state_unit.sv
// State stage: per-motor memory of target, overload count and integral.
// Read on accept, ramp/overload/integral update, write back as the item advances.
// Depends on rpml_pkg.
module rpml_state_unit #(
  parameter int MOTORS        = 8,
  parameter int INTEGRAL_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              in_valid_i,
  input  logic [rpml_pkg::MOTOR_W-1:0]      motor_index_i,
  input  logic [rpml_pkg::RPM_W-1:0]        measured_rpm_i,
  input  logic                              run_enable_i,
  input  logic [rpml_pkg::RPM_W-1:0]        set_rpm_i,
  input  logic [rpml_pkg::STEP_W-1:0]       ramp_step_i,
  input  logic [rpml_pkg::GAIN_W-1:0]       prop_gain_i,
  input  logic [rpml_pkg::GAIN_W-1:0]       integ_gain_i,
  input  logic [rpml_pkg::PWM_W-1:0]        pwm_floor_i,
  input  rpml_pkg::cfg_t                    cfg_i,
  output logic                              s2_valid_o,
  output rpml_pkg::s2_t                     s2_o,
  output logic signed [INTEGRAL_BITS-1:0]   s2_integ_o
);
  import rpml_pkg::*;

  localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int IB = INTEGRAL_BITS;
  localparam int MW = RPM_W + CNT_W + IB;
  localparam logic signed [IB-1:0] IMAX = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0] IMIN = {1'b1, {(IB-1){1'b0}}};

  // state memory, entry = {target, count, integral}
  logic [MW-1:0]    state_mem_q [MOTORS];
  logic [MOTORS-1:0] entry_vld_q;
  logic [MW-1:0]    rd_data_q;
  logic             rd_vld_q;

  // last write, covers the read issued on the same edge
  logic             lw_vld_q;
  logic [AW-1:0]    lw_addr_q;
  logic [MW-1:0]    lw_data_q;

  // stage 1 item
  logic               v1_q;
  logic [MOTOR_W-1:0] motor_q;
  logic [RPM_W-1:0]   meas_q;
  logic               run_q;
  logic [RPM_W-1:0]   set_q;
  logic [STEP_W-1:0]  step_q;
  logic [GAIN_W-1:0]  kp_q;
  logic [GAIN_W-1:0]  ki_q;
  logic [PWM_W-1:0]   flo_q;

  logic               s2_valid_q;
  s2_t                s2_q, s2_d;
  logic signed [IB-1:0] s2_integ_q;

  logic                 accept, oob1, wr_en;
  logic [MOTOR_W+AW-1:0] idx_in_ext, idx1_ext;
  logic [AW-1:0]        addr_in, addr1;
  logic [MW-1:0]        cur, new_state;
  logic [RPM_W-1:0]     tgt_cur, tgt_new;
  logic [CNT_W-1:0]     cnt_cur, cnt_inc, cnt_new;
  logic signed [IB-1:0] integ_cur, integ_new;
  logic signed [IB:0]   isum;
  logic [RPM_W:0]       up_sum;
  logic signed [ERR_W-1:0] step_s, dn_s, err, neg_err;
  logic [RPM_W-1:0]     mag;
  logic                 fault;

  assign accept     = in_valid_i & adv_i;
  assign idx_in_ext = {{AW{1'b0}}, motor_index_i};
  assign idx1_ext   = {{AW{1'b0}}, motor_q};
  assign addr_in    = idx_in_ext[AW-1:0];
  assign addr1      = idx1_ext[AW-1:0];
  assign oob1       = 32'(motor_q) >= 32'(MOTORS);
  assign wr_en      = adv_i & v1_q & ~oob1;

  always_comb begin
    if (lw_vld_q && (lw_addr_q == addr1)) begin
      cur = lw_data_q;
    end else if (rd_vld_q) begin
      cur = rd_data_q;
    end else begin
      cur = '0;
    end
  end

  assign tgt_cur   = cur[MW-1 -: RPM_W];
  assign cnt_cur   = cur[IB +: CNT_W];
  assign integ_cur = $signed(cur[IB-1:0]);

  // ramp
  assign up_sum = {1'b0, tgt_cur} + (RPM_W+1)'(step_q);
  assign step_s = $signed({3'b000, step_q});
  assign dn_s   = $signed({1'b0, tgt_cur}) - step_s;

  always_comb begin
    tgt_new = tgt_cur;
    if (run_q) begin
      if (tgt_cur <= set_q) begin
        tgt_new = (up_sum > {1'b0, set_q}) ? set_q : up_sum[RPM_W-1:0];
      end
    end else if (tgt_cur != '0) begin
      tgt_new = (dn_s <= step_s) ? '0 : dn_s[RPM_W-1:0];
    end
  end

  // error and overload count
  assign err     = $signed({1'b0, tgt_new}) - $signed({1'b0, meas_q});
  assign neg_err = -err;
  assign mag     = err[ERR_W-1] ? neg_err[RPM_W-1:0] : err[RPM_W-1:0];
  assign cnt_inc = (cnt_cur != {CNT_W{1'b1}}) ? cnt_cur + 8'd1 : cnt_cur;

  always_comb begin
    fault   = 1'b0;
    cnt_new = '0;
    if (mag >= cfg_i.error_limit) begin
      if (cnt_inc >= cfg_i.overload_ticks) begin
        fault = 1'b1;
      end else begin
        cnt_new = cnt_inc;
      end
    end
  end

  // saturating integral
  assign isum = {integ_cur[IB-1], integ_cur} + {{(IB+1-ERR_W){err[ERR_W-1]}}, err};

  always_comb begin
    if (isum[IB] != isum[IB-1]) begin
      integ_new = isum[IB] ? IMIN : IMAX;
    end else begin
      integ_new = isum[IB-1:0];
    end
  end

  assign new_state = {tgt_new, cnt_new, integ_new};

  always_comb begin
    s2_d.motor = motor_q;
    s2_d.oob   = oob1;
    s2_d.tgt   = oob1 ? '0 : tgt_new;
    s2_d.fault = oob1 ? 1'b0 : fault;
    s2_d.kp    = kp_q;
    s2_d.ki    = ki_q;
    s2_d.flo   = flo_q;
    s2_d.err   = err;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= state_mem_q[addr_in];
      motor_q   <= motor_index_i;
      meas_q    <= measured_rpm_i;
      run_q     <= run_enable_i;
      set_q     <= set_rpm_i;
      step_q    <= ramp_step_i;
      kp_q      <= prop_gain_i;
      ki_q      <= integ_gain_i;
      flo_q     <= pwm_floor_i;
    end
    if (wr_en) begin
      state_mem_q[addr1] <= new_state;
      lw_data_q          <= new_state;
    end
    if (adv_i) begin
      s2_q       <= s2_d;
      s2_integ_q <= integ_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      s2_valid_q  <= 1'b0;
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      lw_vld_q    <= 1'b0;
      lw_addr_q   <= '0;
    end else begin
      if (adv_i) begin
        v1_q       <= in_valid_i;
        s2_valid_q <= v1_q;
      end
      if (accept) begin
        rd_vld_q <= entry_vld_q[addr_in];
      end
      if (wr_en) begin
        entry_vld_q[addr1] <= 1'b1;
        lw_vld_q           <= 1'b1;
        lw_addr_q          <= addr1;
      end
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;
  assign s2_integ_o = s2_integ_q;

endmodule

### rtl/rpml_pwm_unit.sv
// PWM stage: gain products, per-motor PWM memory, floor/ceiling and result register.
// Depends on rpml_pkg.
module rpml_pwm_unit #(
  parameter int MOTORS         = 8,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int INTEGRAL_BITS  = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             s2_valid_i,
  input  rpml_pkg::s2_t                    s2_i,
  input  logic signed [INTEGRAL_BITS-1:0]  s2_integ_i,
  input  rpml_pkg::cfg_t                   cfg_i,
  output logic                             out_valid_o,
  output logic [rpml_pkg::MOTOR_W-1:0]     out_motor_o,
  output logic [rpml_pkg::PWM_W-1:0]       pwm_value_o,
  output logic [rpml_pkg::RPM_W-1:0]       ramped_target_o,
  output logic                             speed_fault_o
);
  import rpml_pkg::*;

  localparam int AW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int IB   = INTEGRAL_BITS;
  localparam int PPW  = GAIN_W + 1 + ERR_W;
  localparam int PIW  = GAIN_W + 1 + IB;
  localparam int SUMW = PIW + 1;

  logic [PWM_W-1:0]  pwm_mem_q [MOTORS];
  logic [MOTORS-1:0] pwm_vld_q;
  logic [PWM_W-1:0]  rd_pwm_q;
  logic              rd_vld_q;
  logic              lw_vld_q;
  logic [AW-1:0]     lw_addr_q;
  logic [PWM_W-1:0]  lw_pwm_q;

  // stage 3 item
  logic                  v3_q;
  logic [MOTOR_W-1:0]    motor3_q;
  logic                  oob3_q;
  logic [RPM_W-1:0]      tgt3_q;
  logic                  fault3_q;
  logic [PWM_W-1:0]      flo3_q;
  logic signed [PPW-1:0] prod_p_q;
  logic signed [PIW-1:0] prod_i_q;

  logic               out_valid_q;
  logic [MOTOR_W-1:0] out_motor_q;
  logic [PWM_W-1:0]   pwm_q;
  logic [RPM_W-1:0]   tgt_q;
  logic               fault_q;

  logic [MOTOR_W+AW-1:0] idx2_ext, idx3_ext;
  logic [AW-1:0]         addr2, addr3;
  logic signed [PPW-1:0] prod_p_d;
  logic signed [PIW-1:0] prod_i_d;
  logic signed [SUMW-1:0] sum, shifted;
  logic [SUMW:0]         calc;
  logic [PWM_W-1:0]      pwm_old, pwm_new;
  logic                  wr_en;

  assign idx2_ext = {{AW{1'b0}}, s2_i.motor};
  assign idx3_ext = {{AW{1'b0}}, motor3_q};
  assign addr2    = idx2_ext[AW-1:0];
  assign addr3    = idx3_ext[AW-1:0];
  assign wr_en    = adv_i & v3_q & ~oob3_q;

  assign prod_p_d = $signed({1'b0, s2_i.kp}) * s2_i.err;
  assign prod_i_d = $signed({1'b0, s2_i.ki}) * s2_integ_i;

  always_comb begin
    if (lw_vld_q && (lw_addr_q == addr3)) begin
      pwm_old = lw_pwm_q;
    end else if (rd_vld_q) begin
      pwm_old = rd_pwm_q;
    end else begin
      pwm_old = '0;
    end
  end

  // floor shift, then offset; a non-positive scaled term lands on the floor
  assign sum     = SUMW'(prod_i_q) + SUMW'(prod_p_q);
  assign shifted = sum >>> GAIN_FRAC_BITS;
  assign calc    = {1'b0, shifted} + (SUMW+1)'(flo3_q);

  always_comb begin
    if (shifted <= 0) begin
      pwm_new = flo3_q;
    end else if (calc <= (SUMW+1)'(cfg_i.pwm_ceiling)) begin
      pwm_new = calc[PWM_W-1:0];
    end else begin
      pwm_new = pwm_old;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rd_pwm_q  <= pwm_mem_q[addr2];
      motor3_q  <= s2_i.motor;
      oob3_q    <= s2_i.oob;
      tgt3_q    <= s2_i.tgt;
      fault3_q  <= s2_i.fault;
      flo3_q    <= s2_i.flo;
      prod_p_q  <= prod_p_d;
      prod_i_q  <= prod_i_d;
      out_motor_q <= motor3_q;
      pwm_q       <= oob3_q ? '0 : pwm_new;
      tgt_q       <= tgt3_q;
      fault_q     <= fault3_q;
    end
    if (wr_en) begin
      pwm_mem_q[addr3] <= pwm_new;
      lw_pwm_q         <= pwm_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      pwm_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      lw_vld_q    <= 1'b0;
      lw_addr_q   <= '0;
    end else begin
      if (adv_i) begin
        v3_q        <= s2_valid_i;
        out_valid_q <= v3_q;
        rd_vld_q    <= pwm_vld_q[addr2];
      end
      if (wr_en) begin
        pwm_vld_q[addr3] <= 1'b1;
        lw_vld_q         <= 1'b1;
        lw_addr_q        <= addr3;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_motor_o     = out_motor_q;
  assign pwm_value_o     = pwm_q;
  assign ramped_target_o = tgt_q;
  assign speed_fault_o   = fault_q;

endmodule

### rtl/ramped_pi_motor_speed_loop.sv
// Top level of the ramped PI motor speed loop.
// Instantiates rpml_cfg_regs, rpml_state_unit and rpml_pwm_unit; uses rpml_pkg.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-----------------------------------------------
//   in      | in_valid_i/in_ready_o | motor_index, measured_rpm, run_enable, set_rpm,
//           |                       | ramp_step, prop_gain, integ_gain, pwm_floor
//   out     | out_valid_o/out_ready_i | out_motor, pwm_value, ramped_target, speed_fault
//   cfg     | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// Four-stage pipeline: accept/state read, state update and write-back, gain
// multiply plus PWM read, PWM select and write-back into the result register.
// One transaction per cycle sustained while results are taken; out_valid_o rises
// when the item reaches the result register.
// Reset clears the valid bits of both per-motor memories at once, so every
// motor starts at zero with no clearing pass. A stalled result freezes the
// whole pipeline; in_ready_o stays high while the result register is empty or
// being taken.
module ramped_pi_motor_speed_loop #(
  parameter int MOTORS         = 8,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int INTEGRAL_BITS  = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rpml_pkg::MOTOR_W-1:0] motor_index_i,
  input  logic [rpml_pkg::RPM_W-1:0]  measured_rpm_i,
  input  logic                        run_enable_i,
  input  logic [rpml_pkg::RPM_W-1:0]  set_rpm_i,
  input  logic [rpml_pkg::STEP_W-1:0] ramp_step_i,
  input  logic [rpml_pkg::GAIN_W-1:0] prop_gain_i,
  input  logic [rpml_pkg::GAIN_W-1:0] integ_gain_i,
  input  logic [rpml_pkg::PWM_W-1:0]  pwm_floor_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rpml_pkg::MOTOR_W-1:0] out_motor_o,
  output logic [rpml_pkg::PWM_W-1:0]  pwm_value_o,
  output logic [rpml_pkg::RPM_W-1:0]  ramped_target_o,
  output logic                        speed_fault_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpml_pkg::APB_AW-1:0] paddr,
  input  logic [rpml_pkg::APB_DW-1:0] pwdata,
  output logic [rpml_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import rpml_pkg::*;

  cfg_t                           cfg;
  logic                           adv;
  logic                           s2_valid;
  s2_t                            s2;
  logic signed [INTEGRAL_BITS-1:0] s2_integ;
  logic                           out_valid;

  // Every stage moves together whenever the result register can take a new value.
  assign adv         = ~out_valid | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid;

  rpml_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // target / overload count / integral, read-modify-write with last-write bypass
  rpml_state_unit #(
    .MOTORS        (MOTORS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .in_valid_i     (in_valid_i),
    .motor_index_i  (motor_index_i),
    .measured_rpm_i (measured_rpm_i),
    .run_enable_i   (run_enable_i),
    .set_rpm_i      (set_rpm_i),
    .ramp_step_i    (ramp_step_i),
    .prop_gain_i    (prop_gain_i),
    .integ_gain_i   (integ_gain_i),
    .pwm_floor_i    (pwm_floor_i),
    .cfg_i          (cfg),
    .s2_valid_o     (s2_valid),
    .s2_o           (s2),
    .s2_integ_o     (s2_integ)
  );

  // gain products, stored PWM for the hold-above-ceiling case, result register
  rpml_pwm_unit #(
    .MOTORS         (MOTORS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .INTEGRAL_BITS  (INTEGRAL_BITS)
  ) u_pwm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .s2_valid_i      (s2_valid),
    .s2_i            (s2),
    .s2_integ_i      (s2_integ),
    .cfg_i           (cfg),
    .out_valid_o     (out_valid),
    .out_motor_o     (out_motor_o),
    .pwm_value_o     (pwm_value_o),
    .ramped_target_o (ramped_target_o),
    .speed_fault_o   (speed_fault_o)
  );

endmodule
